### hw/rtl/nrc_pkg.sv
// Shared constants and types for the normalized RGB 3x3 convolution core.
// No dependencies.
package nrc_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COEF_BITS_DEF = 12;
  localparam int COEF_FRAC     = 8;
  localparam int PIX_BITS      = 24;
  localparam int CH_BITS       = 8;

  localparam int WIDTH_REG_BITS  = 12;
  localparam int HEIGHT_REG_BITS = 16;
  localparam int CFG_IDX_BITS    = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_TOP   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_MID   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_BOT   = 3'd4;

  localparam logic [CH_BITS-1:0] CH_MAX = 8'd255;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } nrc_div_ctl_t;

endpackage

### hw/rtl/nrc_pix_in_if.sv
// Input pixel channel: valid/ready handshake with RGB payload and flush flag.
// Depends on nrc_pkg.
interface nrc_pix_in_if
  import nrc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] red_in;
  logic [CH_BITS-1:0] green_in;
  logic [CH_BITS-1:0] blue_in;
  logic               flush;

  modport source (output valid, red_in, green_in, blue_in, flush, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

### hw/rtl/nrc_pix_out_if.sv
// Result pixel channel: valid/ready handshake with RGB payload and frame end.
// Depends on nrc_pkg.
interface nrc_pix_out_if
  import nrc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] red_out;
  logic [CH_BITS-1:0] green_out;
  logic [CH_BITS-1:0] blue_out;
  logic               frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

### hw/rtl/nrc_divider.sv
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// Quotient clamped to 0..255. Depends on nrc_pkg.
module nrc_divider
  import nrc_pkg::*;
#(
  parameter int NW = 27,
  parameter int DW = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nrc_div_ctl_t            ctl_in,
  output nrc_div_ctl_t            ctl_out,
  input  logic [2:0][NW-1:0]      num,
  input  logic [DW-1:0]           den,
  output logic [2:0][CH_BITS-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic [2:0][NW-1:0] q_r, q_nxt;
  logic [2:0][DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0]      den_r;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DW:0]        trial [3];

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_r[i], q_r[i][NW-1]};
    end
    if (ctl_in.start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CNTW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        if (trial[i] >= {1'b0, den_r}) begin
          rem_nxt[i] = DW'(trial[i] - {1'b0, den_r});
          q_nxt[i]   = {q_r[i][NW-2:0], 1'b1};
        end else begin
          rem_nxt[i] = trial[i][DW-1:0];
          q_nxt[i]   = {q_r[i][NW-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl_in.start) den_r <= den;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo[i] = (q_r[i] > NW'(CH_MAX)) ? CH_MAX : q_r[i][CH_BITS-1:0];
    end
    ctl_out.start = 1'b0;
    ctl_out.busy  = busy_r;
    ctl_out.done  = done_r;
  end

endmodule

### hw/rtl/normalized_rgb_convolution_core.sv
// Top level of the normalized RGB 3x3 convolution core: line memories,
// window, tap accumulator and output register. Depends on nrc_pkg,
// nrc_pix_in_if, nrc_pix_out_if and nrc_divider.
//
//  channel   direction  handshake        payload
//  in_ch     sink       valid/ready      red_in, green_in, blue_in, flush
//  out_ch    source     valid/ready      red_out, green_out, blue_out, frame_end
//  cfg_*     sink       cfg_we only      cfg_index, cfg_wdata
//
// Steps: an item that gives no result passes through the transfer and the line
// memory read; one that gives a result then takes the nine taps (one tap per
// cycle), the divider start, the divider (one quotient bit per cycle) and the
// push into the output register, which waits while the output is stalled.
// The bit-serial divider is the longest step. Reset is synchronous, active low;
// the line memories are not cleared, since taps outside the image are masked.
// A finished result sits in the output register; the next item is taken
// while it waits, and a second result waits in its final state.
module normalized_rgb_convolution_core
  import nrc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  nrc_pix_in_if.sink               in_ch,
  nrc_pix_out_if.source            out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [3*COEF_BITS-1:0]   cfg_wdata
);

  localparam int KRW  = 3 * COEF_BITS;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int LW   = $clog2(MAX_WIDTH + 2);
  localparam int RW   = HEIGHT_REG_BITS;
  localparam int PW   = COEF_BITS + CH_BITS + 1;   // one product
  localparam int SW   = PW + 4;                    // sum of nine products
  localparam int KW   = COEF_BITS + 4;             // sum of nine coefficients
  localparam int NW   = SW + 1;                    // 2*s + k
  localparam int DW   = KW;                        // 2*k

  // State codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_DIVS = 3'd3;
  localparam logic [2:0] ST_DIVW = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  // Configuration registers
  logic [WIDTH_REG_BITS-1:0]  width_r;
  logic [HEIGHT_REG_BITS-1:0] height_r;
  logic [KRW-1:0]             krow_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_REG_BITS'(1);
      height_r  <= HEIGHT_REG_BITS'(1);
      krow_r[0] <= '0;
      krow_r[1] <= KRW'(256);
      krow_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r   <= cfg_wdata[WIDTH_REG_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_r  <= cfg_wdata[HEIGHT_REG_BITS-1:0];
        CFG_KERNEL_TOP:   krow_r[0] <= cfg_wdata;
        CFG_KERNEL_MID:   krow_r[1] <= cfg_wdata;
        CFG_KERNEL_BOT:   krow_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective sizes: width clamped to 1..MAX_WIDTH, height at least 1
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  always_comb begin
    if (width_r == '0) w_eff = WW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);
    h_eff = (height_r == '0) ? RW'(1) : height_r;
  end

  // Control and counters
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [LW-1:0] lead_r, lead_nxt;
  logic [1:0]    tr_r, tr_nxt, tc_r, tc_nxt;

  logic [PIX_BITS-1:0] pix_r;
  logic [CW-1:0]       addr_r;

  // Line memories: row above and row two above
  logic [PIX_BITS-1:0] line1_mem [MAX_WIDTH];
  logic [PIX_BITS-1:0] line2_mem [MAX_WIDTH];
  logic [PIX_BITS-1:0] up1_r, up2_r;

  // 3x3 window, [row][col], col 2 newest
  logic [PIX_BITS-1:0] win_r [3][3];

  logic signed [SW-1:0] acc_r [3];
  logic signed [KW-1:0] ksum_r;

  logic                     out_valid_r;
  logic [2:0][CH_BITS-1:0]  out_pix_r;
  logic                     out_end_r;

  nrc_div_ctl_t             div_ctl, div_stat;
  logic [2:0][NW-1:0]       div_num;
  logic [DW-1:0]            div_den;
  logic [2:0][CH_BITS-1:0]  div_quo;
  logic [2:0]               pos_r;

  logic in_fire, draining, take_item;
  assign draining  = in_row_r >= h_eff;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire   = in_ch.valid && in_ch.ready;
  // A flush transfer while pixels are still due is dropped
  assign take_item = in_fire && (draining || !in_ch.flush);

  logic emit, last, out_free;
  assign emit     = lead_r >= (LW'(w_eff) + 1'b1);
  assign last     = (WW'(out_col_r) + 1'b1 >= w_eff) &&
                    ({1'b0, out_row_r} + 1'b1 >= {1'b0, h_eff});
  assign out_free = !out_valid_r || out_ch.ready;

  // Tap bounds for the current output position
  logic [2:0] row_ok, col_ok;
  always_comb begin
    row_ok[0] = (out_row_r != '0) && (out_row_r - 1'b1 < h_eff);
    row_ok[1] = out_row_r < h_eff;
    row_ok[2] = ({1'b0, out_row_r} + 1'b1) < {1'b0, h_eff};
    col_ok[0] = (out_col_r != '0) && (WW'(out_col_r) - 1'b1 < w_eff);
    col_ok[1] = WW'(out_col_r) < w_eff;
    col_ok[2] = (WW'(out_col_r) + 1'b1) < w_eff;
  end

  // Current tap: coefficient and pixel, both zero when outside the image
  logic                       tap_ok;
  logic signed [COEF_BITS-1:0] coef;
  logic [PIX_BITS-1:0]        tap_pix;
  always_comb begin
    tap_ok  = row_ok[tr_r] && col_ok[tc_r];
    coef    = tap_ok ? $signed(krow_r[tr_r][tc_r*COEF_BITS +: COEF_BITS]) : '0;
    tap_pix = tap_ok ? win_r[tr_r][tc_r] : '0;
  end

  always_comb begin
    state_nxt   = state_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    lead_nxt    = lead_r;
    tr_nxt      = tr_r;
    tc_nxt      = tc_r;
    div_ctl     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take_item) state_nxt = ST_RD;
      end
      ST_RD: begin
        if (!emit) lead_nxt = lead_r + 1'b1;
        if (WW'(in_col_r) + 1'b1 >= w_eff) begin
          in_col_nxt = '0;
          if (in_row_r < h_eff) in_row_nxt = in_row_r + 1'b1;
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
        tr_nxt = '0;
        tc_nxt = '0;
        state_nxt = emit ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        if (tc_r == 2'd2) begin
          tc_nxt = '0;
          if (tr_r == 2'd2) state_nxt = ST_DIVS;
          else tr_nxt = tr_r + 1'b1;
        end else begin
          tc_nxt = tc_r + 1'b1;
        end
      end
      ST_DIVS: begin
        div_ctl.start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_stat.done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (last) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
            lead_nxt    = '0;
          end else if (WW'(out_col_r) + 1'b1 >= w_eff) begin
            out_col_nxt = '0;
            if (out_row_r != {RW{1'b1}}) out_row_nxt = out_row_r + 1'b1;
          end else begin
            out_col_nxt = out_col_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lead_r    <= '0;
      tr_r      <= '0;
      tc_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lead_r    <= lead_nxt;
      tr_r      <= tr_nxt;
      tc_r      <= tc_nxt;
    end
  end

  // Item capture and line memory read; pixel is zero while draining
  always_ff @(posedge clk) begin
    if (take_item) begin
      pix_r  <= draining ? '0 : {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
      addr_r <= in_col_r;
      up1_r  <= line1_mem[in_col_r];
      up2_r  <= line2_mem[in_col_r];
    end
  end

  // Write-back: rows move down one line
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      line1_mem[addr_r] <= pix_r;
      line2_mem[addr_r] <= up1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          win_r[r][c] <= '0;
    end else if (state_r == ST_RD) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up2_r;
      win_r[1][2] <= up1_r;
      win_r[2][2] <= pix_r;
    end
  end

  // Tap accumulator: three small multiplies per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      ksum_r <= '0;
    end else if (state_r == ST_MAC) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= acc_r[i] + SW'(coef *
                    $signed({1'b0, tap_pix[(2-i)*CH_BITS +: CH_BITS]}));
      end
      ksum_r <= ksum_r + KW'(coef);
    end
  end

  // Divider operands: non-positive kernel sum means 1.0
  logic signed [KW-1:0] k_use;
  always_comb begin
    k_use   = (ksum_r <= 0) ? KW'(1 << COEF_FRAC) : ksum_r;
    div_den = DW'({k_use, 1'b0});
    for (int i = 0; i < 3; i++) begin
      div_num[i] = NW'({acc_r[i], 1'b0}) + NW'(k_use);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIVS) begin
      for (int i = 0; i < 3; i++) pos_r[i] <= acc_r[i] > 0;
    end
  end

  nrc_divider #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (div_ctl),
    .ctl_out (div_stat),
    .num     (div_num),
    .den     (div_den),
    .quo     (div_quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_PUSH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == ST_PUSH && out_free) begin
      for (int i = 0; i < 3; i++) out_pix_r[i] <= pos_r[i] ? div_quo[i] : '0;
      out_end_r <= last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_pix_r[0];
  assign out_ch.green_out = out_pix_r[1];
  assign out_ch.blue_out  = out_pix_r[2];
  assign out_ch.frame_end = out_end_r;

endmodule

### bench/tb.sv
// Self-checking bench for normalized_rgb_convolution_core: pixel frames in,
// filtered pixels out, each checked against a bit-exact predictor in this file.
// Depends on nrc_pkg, nrc_pix_in_if, nrc_pix_out_if and the core itself.
`timescale 1ns / 1ps

module tb;
  import nrc_pkg::*;

  localparam int LINE_MAX = MAX_WIDTH_DEF;
  localparam int CB       = COEF_BITS_DEF;
  localparam int SETTLE   = 80;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_out_t;

  // how a directed row is checked
  typedef enum logic [1:0] {BY_MODEL, TYPED_PIXEL, TYPED_NONE} row_check_t;

  typedef struct {
    logic       flush;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    row_check_t check;
    pixel_out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [3*CB-1:0] cfg_wdata = '0;

  nrc_pix_in_if  in_ch ();
  nrc_pix_out_if out_ch ();

  normalized_rgb_convolution_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: registers, two line stores, 3x3 window, frame counters.
  // ---------------------------------------------------------------------------
  logic [11:0]   reg_width;
  logic [15:0]   reg_height;
  logic [3*CB-1:0] reg_kernel [3];
  logic [23:0]   line_mem [2*LINE_MAX];
  logic [23:0]   win [3][3];
  int unsigned   in_col, in_row, out_col, out_row, lead;

  pixel_out_t pending_pixels[$];
  row_check_t next_check = BY_MODEL;
  pixel_out_t next_want;
  int errors = 0;
  int n_items = 0, n_results = 0, n_frames = 0, n_ignored = 0;
  bit quiet = 1'b0;   // no idling on either side while set

  function automatic int unsigned used_width();
    if (reg_width == 0) return 1;
    return (reg_width > LINE_MAX) ? LINE_MAX : reg_width;
  endfunction

  function automatic int unsigned used_height();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  function automatic logic [7:0] normalize(longint sum, longint ksum);
    longint unsigned q;
    if (sum <= 0) return 8'd0;
    q = (2 * longint'(sum) + ksum) / (2 * ksum);
    return (q > 255) ? CH_MAX : q[7:0];
  endfunction

  // Advance the predictor by one accepted transfer; returns 1 if it yields
  // a filtered pixel.
  function automatic bit convolve_step(logic fl, logic [23:0] pix_in,
                                       output pixel_out_t res);
    int unsigned w, h, col;
    bit draining, emit, last;
    logic [23:0] pix, up1, up2, p;
    longint sr, sg, sb, sk, k;
    int y, x;
    w = used_width();
    h = used_height();
    res = '0;
    draining = in_row >= h;
    // flush while the frame is still arriving: dropped outright
    if (!draining && fl) return 1'b0;
    pix = draining ? 24'd0 : pix_in;
    col = (in_col < LINE_MAX) ? in_col : LINE_MAX - 1;
    up1 = line_mem[col];
    up2 = line_mem[LINE_MAX + col];
    line_mem[LINE_MAX + col] = up1;
    line_mem[col] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = pix;
    emit = lead >= w + 1;
    if (!emit) lead++;
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < h) in_row++;
    end else begin
      in_col++;
    end
    if (!emit) return 1'b0;
    sr = 0; sg = 0; sb = 0; sk = 0;
    for (int r = 0; r < 3; r++) begin
      y = int'(out_row) - 1 + r;
      if (y < 0 || y >= int'(h)) continue;
      for (int c = 0; c < 3; c++) begin
        x = int'(out_col) - 1 + c;
        if (x < 0 || x >= int'(w)) continue;
        k = longint'($signed(reg_kernel[r][c*CB +: CB]));
        p = win[r][c];
        sr += k * longint'(p[23:16]);
        sg += k * longint'(p[15:8]);
        sb += k * longint'(p[7:0]);
        sk += k;
      end
    end
    if (sk <= 0) sk = longint'(1) << COEF_FRAC;
    res.red   = normalize(sr, sk);
    res.green = normalize(sg, sk);
    res.blue  = normalize(sb, sk);
    last = (out_col + 1 >= w) && (out_row + 1 >= h);
    res.frame_end = last;
    if (last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; lead = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      if (out_row < 16'hFFFF) out_row++;
    end else begin
      out_col++;
    end
    return 1'b1;
  endfunction

  task automatic report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: predict on each input transfer, check each
  // output transfer against the oldest waiting pixel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_out_t res, got, exp_pix;
    bit has;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      has = convolve_step(in_ch.flush, {in_ch.red_in, in_ch.green_in, in_ch.blue_in}, res);
      n_items++;
      if (next_check == TYPED_NONE && has)
        report("table row gave a pixel where none was due");
      if (next_check == TYPED_PIXEL) begin
        if (!has) report("table row gave no pixel where one was due");
        else pending_pixels.push_back(next_want);
      end else if (has) begin
        pending_pixels.push_back(res);
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.frame_end};
      n_results++;
      if (got.frame_end) n_frames++;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel %h", got));
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (got.red != exp_pix.red)
          report($sformatf("red %0d, want %0d", got.red, exp_pix.red));
        if (got.green != exp_pix.green)
          report($sformatf("green %0d, want %0d", got.green, exp_pix.green));
        if (got.blue != exp_pix.blue)
          report($sformatf("blue %0d, want %0d", got.blue, exp_pix.blue));
        if (got.frame_end != exp_pix.frame_end)
          report($sformatf("frame_end %0b, want %0b", got.frame_end, exp_pix.frame_end));
      end
    end
  end

  // Result side back-pressure, off during quiet stretches.
  always @(negedge clk)
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);

  // ---------------------------------------------------------------------------
  // Driving tasks; everything changes on the falling edge.
  // ---------------------------------------------------------------------------
  task automatic send(logic fl, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!quiet && $urandom_range(99) < 17) begin
      in_ch.valid = 1'b0;
      in_ch.red_in = $urandom; in_ch.green_in = $urandom; in_ch.blue_in = $urandom;
      in_ch.flush = $urandom;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.flush = fl;
    in_ch.red_in = r; in_ch.green_in = g; in_ch.blue_in = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_random(logic fl);
    send(fl, $urandom, $urandom, $urandom);
  endtask

  // Wait for every expected pixel, then let in-flight no-result items settle.
  task automatic wait_idle();
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [3*CB-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  reg_width  = val[11:0];
      CFG_IMAGE_HEIGHT: reg_height = val[15:0];
      CFG_KERNEL_TOP:   reg_kernel[0] = val;
      CFG_KERNEL_MID:   reg_kernel[1] = val;
      CFG_KERNEL_BOT:   reg_kernel[2] = val;
      default: ;
    endcase
  endtask

  // Drain a frame: any item counts once all pixels are in, so mix flush
  // items with stray pixel data until the predictor's counters clear.
  task automatic drain_frame();
    do begin
      @(negedge clk);
      send_random($urandom_range(1));
    end while (lead != 0 || in_row != 0);
  endtask

  // One well-formed frame, sprinkled with ignored flushes at noise_pct.
  task automatic run_frame(int noise_pct);
    int unsigned total;
    total = used_width() * used_height();
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_random(1'b1);
        n_ignored++;
      end
      send_random(1'b0);
    end
    drain_frame();
  endtask

  function automatic logic [3*CB-1:0] pick_kernel();
    case ($urandom_range(6))
      0: return {12'h000, 12'h100, 12'h000};
      1: return {12'h100, 12'h100, 12'h100};
      2: return {12'h7FF, 12'h7FF, 12'h7FF};   // largest positive taps
      3: return {12'h800, 12'h800, 12'h800};   // most negative taps
      4: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Directed rows at reset settings (1x1 frame): the reset kernel's only
  // tap is the left one of the center row, which lies outside a 1x1 frame,
  // so every result is black with frame_end set, two items after its pixel.
  stim_row_t table_rows[] = '{
    '{1'b1, 8'd11,  8'd22,  8'd33,  TYPED_NONE,  '0},  // flush mid-frame: dropped
    '{1'b0, 8'd255, 8'd0,   8'd170, TYPED_NONE,  '0},
    '{1'b0, 8'd7,   8'd8,   8'd9,   TYPED_NONE,  '0},  // pixel while draining
    '{1'b1, 8'd0,   8'd0,   8'd0,   TYPED_PIXEL, {8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b0, 8'd0,   8'd255, 8'd85,  TYPED_NONE,  '0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   TYPED_NONE,  '0},
    '{1'b0, 8'd1,   8'd2,   8'd3,   TYPED_PIXEL, {8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b0, 8'd128, 8'd1,   8'd254, TYPED_NONE,  '0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   TYPED_NONE,  '0},
    '{1'b1, 8'd0,   8'd0,   8'd0,   TYPED_PIXEL, {8'd0, 8'd0, 8'd0, 1'b1}}
  };

  initial begin
    int frames_left;
    in_ch.valid = 1'b0;
    in_ch.red_in = '0; in_ch.green_in = '0; in_ch.blue_in = '0; in_ch.flush = 1'b0;
    out_ch.ready = 1'b0;
    reg_width = 12'd1;
    reg_height = 16'd1;
    reg_kernel[0] = '0;
    reg_kernel[1] = 36'd256;
    reg_kernel[2] = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; lead = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table, walked in order.
    foreach (table_rows[i]) begin
      next_check = table_rows[i].check;
      next_want = table_rows[i].want;
      send(table_rows[i].flush, table_rows[i].red, table_rows[i].green,
           table_rows[i].blue);
    end
    wait_idle();
    next_check = BY_MODEL;

    // Tallest frame: start it, then cut the height while idle mid-frame.
    write_reg(CFG_IMAGE_WIDTH, 36'd1);
    write_reg(CFG_IMAGE_HEIGHT, 36'hFFFF);
    write_reg(CFG_KERNEL_TOP, {12'h000, 12'h040, 12'h000});
    write_reg(CFG_KERNEL_MID, {12'h000, 12'h100, 12'h000});
    write_reg(CFG_KERNEL_BOT, {12'hFC0, 12'h040, 12'h000});
    repeat (6) send_random(1'b0);
    wait_idle();   // sender holds off until every pixel so far is out
    write_reg(CFG_IMAGE_HEIGHT, 36'd3);
    drain_frame();
    wait_idle();

    // A 40x3 frame with no idling on either side.
    write_reg(CFG_IMAGE_WIDTH, 36'd40);
    write_reg(CFG_IMAGE_HEIGHT, 36'd3);
    write_reg(CFG_KERNEL_TOP, pick_kernel());
    write_reg(CFG_KERNEL_MID, pick_kernel());
    write_reg(CFG_KERNEL_BOT, pick_kernel());
    quiet = 1'b1;
    run_frame(0);
    quiet = 1'b0;
    wait_idle();

    // Random phases: new settings, a few well-formed frames with noise.
    while (n_items < 1300) begin
      case ($urandom_range(5))
        0: write_reg(CFG_IMAGE_WIDTH, 36'd0);
        1: write_reg(CFG_IMAGE_WIDTH, 36'd1);
        default: write_reg(CFG_IMAGE_WIDTH, $urandom_range(12, 2));
      endcase
      case ($urandom_range(5))
        0: write_reg(CFG_IMAGE_HEIGHT, 36'd0);
        1: write_reg(CFG_IMAGE_HEIGHT, 36'd1);
        default: write_reg(CFG_IMAGE_HEIGHT, $urandom_range(8, 2));
      endcase
      write_reg(CFG_KERNEL_TOP, pick_kernel());
      write_reg(CFG_KERNEL_MID, pick_kernel());
      write_reg(CFG_KERNEL_BOT, pick_kernel());
      frames_left = $urandom_range(3, 1);
      repeat (frames_left) run_frame(($urandom_range(3) == 0) ? 25 : 3);
      wait_idle();
    end

    // All stimulus in; give the tail a bounded time to come out.
    for (int t = 0; t < 5000 && pending_pixels.size() != 0; t++) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (pending_pixels.size() != 0)
      report($sformatf("%0d pixels never came out", pending_pixels.size()));
    $display("covered %0d transfers in, %0d filtered pixels, %0d frames, %0d dropped flushes",
             n_items, n_results, n_frames, n_ignored);
    $display("sizes from 1x1 up to 40x3; kernel extremes and mid-frame resize");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### normalized_rgb_convolution_core.f
hw/rtl/nrc_pkg.sv
hw/rtl/nrc_pix_in_if.sv
hw/rtl/nrc_pix_out_if.sv
hw/rtl/nrc_divider.sv
hw/rtl/normalized_rgb_convolution_core.sv
bench/tb.sv
